### design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/rsgate_pkg.sv
// Types, codes and constants of the redundancy switch request gate.
// Used by rsgate_decode and redundancy_switch_request_gate; depends on nothing.
package rsgate_pkg;

   localparam int UNIT_BITS = 8;
   localparam logic [7:0] UNIT_KEEP =
      (UNIT_BITS >= 8) ? 8'hFF : 8'((16'd1 << UNIT_BITS) - 16'd1);

   localparam int RSP_DEPTH = 3;

   typedef enum logic [2:0] {
      FUNC_SELF_REQ = 3'd0,
      FUNC_RESET_REQ = 3'd1,
      FUNC_READY = 3'd2,
      FUNC_VELOCITY = 3'd3,
      FUNC_CONTROL = 3'd4,
      FUNC_SWITCHER = 3'd5,
      FUNC_UNIT = 3'd6,
      FUNC_PEER = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      CMD_LOG = 3'd0,
      CMD_SELF = 3'd1,
      CMD_RESET = 3'd2,
      CMD_RESULT = 3'd3,
      CMD_DIAG = 3'd4,
      CMD_READY = 3'd5,
      CMD_UNIT = 3'd6,
      CMD_PEER = 3'd7
   } cmd_kind_type;

   typedef enum logic [1:0] {
      LVL_DEBUG = 2'd0,
      LVL_INFO = 2'd1,
      LVL_WARN = 2'd2,
      LVL_ERROR = 2'd3
   } log_level_type;

   typedef enum logic [1:0] {
      RSN_NONE = 2'd0,
      RSN_IGNORED = 2'd1,
      RSN_NOT_NEEDED = 2'd2,
      RSN_ERROR = 2'd3
   } reason_type;

   // Outcome numbers carried in message_id.
   localparam logic [4:0] MSG_SELF_NOT_READY = 5'd0;
   localparam logic [4:0] MSG_SELF_NOT_AUTO = 5'd1;
   localparam logic [4:0] MSG_SELF_NO_SWITCHER = 5'd2;
   localparam logic [4:0] MSG_SELF_ALREADY = 5'd3;
   localparam logic [4:0] MSG_SELF_FAULT = 5'd4;
   localparam logic [4:0] MSG_SELF_ACCEPTED = 5'd5;
   localparam logic [4:0] MSG_SELF_TRANSIT = 5'd6;
   localparam logic [4:0] MSG_RST_MOVING = 5'd7;
   localparam logic [4:0] MSG_RST_INIT = 5'd8;
   localparam logic [4:0] MSG_RST_NO_SWITCHER = 5'd9;
   localparam logic [4:0] MSG_RST_ACCEPTED = 5'd10;
   localparam logic [4:0] MSG_RST_NOT_NEEDED = 5'd11;
   localparam logic [4:0] MSG_RST_FAULT = 5'd12;
   localparam logic [4:0] MSG_RST_TRANSIT = 5'd13;
   localparam logic [4:0] MSG_READY = 5'd14;
   localparam logic [4:0] MSG_VELOCITY = 5'd15;
   localparam logic [4:0] MSG_CONTROL = 5'd16;
   localparam logic [4:0] MSG_SWITCHER = 5'd17;
   localparam logic [4:0] MSG_PEER = 5'd18;
   localparam logic [4:0] MSG_UNIT = 5'd0;

   // Packed so that bit 0 is ready_known and bit 10 is peer_timed_out.
   typedef struct packed {
      logic       peer_timed_out;
      logic [2:0] switcher_flags;
      logic       switcher_known;
      logic       vehicle_stopped;
      logic       velocity_known;
      logic       control_auto;
      logic       control_known;
      logic       ready_true;
      logic       ready_known;
   } status_type;

   typedef struct packed {
      func_type   func;
      logic       flag_value;
      logic       sw_stable;
      logic       sw_interrupted;
      logic       sw_fault;
      logic [7:0] unit_mask;
   } req_type;

   typedef struct packed {
      cmd_kind_type  cmd_kind;
      log_level_type log_level;
      logic [4:0]    message_id;
      logic          reset_accepted;
      reason_type    reject_reason;
      logic          flag_out;
      logic [7:0]    unit_out;
      logic [10:0]   status_word;
   } rsp_type;

   // Up to three responses for one request, and how many of them are used.
   typedef struct packed {
      rsp_type [RSP_DEPTH-1:0] res;
      logic [1:0]              cnt;
   } plan_type;

endpackage

### design/rsgate_decode.sv
// Combinational decode of one request against the stored status.
// Gives the list of responses and the next status; uses rsgate_pkg.
module rsgate_decode (
   input  rsgate_pkg::req_type    item,
   input  rsgate_pkg::status_type status,
   output rsgate_pkg::plan_type   plan,
   output rsgate_pkg::status_type status_next
);

   function automatic rsgate_pkg::rsp_type mk(
      input rsgate_pkg::cmd_kind_type  kind,
      input rsgate_pkg::log_level_type level,
      input logic [4:0]                msg,
      input logic                      acc,
      input rsgate_pkg::reason_type    reason,
      input logic                      flag,
      input logic [7:0]                unit,
      input logic [10:0]               snap
   );
      rsgate_pkg::rsp_type r;
      r.cmd_kind = kind;
      r.log_level = level;
      r.message_id = msg;
      r.reset_accepted = acc;
      r.reject_reason = reason;
      r.flag_out = flag;
      r.unit_out = unit;
      r.status_word = snap;
      return r;
   endfunction

   function automatic rsgate_pkg::rsp_type log_rsp(
      input rsgate_pkg::log_level_type level,
      input logic [4:0]                msg
   );
      return mk(rsgate_pkg::CMD_LOG, level, msg, 1'b0, rsgate_pkg::RSN_NONE, 1'b0, 8'd0,
                11'd0);
   endfunction

   // An accepted reset also issues the reset command ahead of the result.
   function automatic rsgate_pkg::plan_type reset_plan(
      input logic                      acc,
      input rsgate_pkg::reason_type    reason,
      input rsgate_pkg::log_level_type level,
      input logic [4:0]                msg
   );
      rsgate_pkg::plan_type p;
      rsgate_pkg::rsp_type  res_rsp;
      p = '0;
      res_rsp = mk(rsgate_pkg::CMD_RESULT, rsgate_pkg::LVL_DEBUG, msg, acc, reason, 1'b0,
                   8'd0, 11'd0);
      if (acc) begin
         p.res[0] = mk(rsgate_pkg::CMD_RESET, rsgate_pkg::LVL_DEBUG, msg, 1'b0,
                       rsgate_pkg::RSN_NONE, 1'b0, 8'd0, 11'd0);
         p.res[1] = res_rsp;
         p.res[2] = log_rsp(level, msg);
         p.cnt = 2'd3;
      end else begin
         p.res[0] = res_rsp;
         p.res[1] = log_rsp(level, msg);
         p.cnt = 2'd2;
      end
      return p;
   endfunction

   logic       rdy;
   logic       auto_ok;
   logic       sw_stab;
   logic       sw_intr;
   logic       sw_flt;
   logic [2:0] new_flags;
   logic       changed;

   assign rdy = status.ready_known & status.ready_true;
   assign auto_ok = status.control_known & status.control_auto;
   assign sw_stab = status.switcher_flags[0];
   assign sw_intr = status.switcher_flags[1];
   assign sw_flt = status.switcher_flags[2];
   assign new_flags = {item.sw_fault, item.sw_interrupted, item.sw_stable};

   always_comb begin
      plan = '0;
      status_next = status;
      changed = 1'b0;
      unique case (item.func)
         rsgate_pkg::FUNC_SELF_REQ: begin
            plan.cnt = 2'd1;
            priority if (!rdy) begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_DEBUG, rsgate_pkg::MSG_SELF_NOT_READY);
            end else if (!auto_ok) begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_DEBUG, rsgate_pkg::MSG_SELF_NOT_AUTO);
            end else if (!status.switcher_known) begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_WARN, rsgate_pkg::MSG_SELF_NO_SWITCHER);
            end else if (sw_intr) begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_DEBUG, rsgate_pkg::MSG_SELF_ALREADY);
            end else if (sw_flt) begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_ERROR, rsgate_pkg::MSG_SELF_FAULT);
            end else if (sw_stab) begin
               plan.res[0] = mk(rsgate_pkg::CMD_SELF, rsgate_pkg::LVL_DEBUG,
                                rsgate_pkg::MSG_SELF_ACCEPTED, 1'b0, rsgate_pkg::RSN_NONE,
                                1'b0, 8'd0, 11'd0);
               plan.res[1] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_SELF_ACCEPTED);
               plan.cnt = 2'd2;
            end else begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_SELF_TRANSIT);
            end
         end
         rsgate_pkg::FUNC_RESET_REQ: begin
            // With the velocity unknown the vehicle is not taken to be moving.
            priority if (status.velocity_known && !status.vehicle_stopped) begin
               plan = reset_plan(1'b0, rsgate_pkg::RSN_IGNORED, rsgate_pkg::LVL_WARN,
                                 rsgate_pkg::MSG_RST_MOVING);
            end else if (!rdy) begin
               plan = reset_plan(1'b1, rsgate_pkg::RSN_NONE, rsgate_pkg::LVL_INFO,
                                 rsgate_pkg::MSG_RST_INIT);
            end else if (!status.switcher_known) begin
               plan = reset_plan(1'b0, rsgate_pkg::RSN_ERROR, rsgate_pkg::LVL_ERROR,
                                 rsgate_pkg::MSG_RST_NO_SWITCHER);
            end else if (sw_intr) begin
               plan = reset_plan(1'b1, rsgate_pkg::RSN_NONE, rsgate_pkg::LVL_INFO,
                                 rsgate_pkg::MSG_RST_ACCEPTED);
            end else if (sw_stab) begin
               plan = reset_plan(1'b0, rsgate_pkg::RSN_NOT_NEEDED, rsgate_pkg::LVL_INFO,
                                 rsgate_pkg::MSG_RST_NOT_NEEDED);
            end else if (sw_flt) begin
               plan = reset_plan(1'b0, rsgate_pkg::RSN_ERROR, rsgate_pkg::LVL_ERROR,
                                 rsgate_pkg::MSG_RST_FAULT);
            end else begin
               plan = reset_plan(1'b0, rsgate_pkg::RSN_ERROR, rsgate_pkg::LVL_WARN,
                                 rsgate_pkg::MSG_RST_TRANSIT);
            end
         end
         rsgate_pkg::FUNC_READY: begin
            changed = !status.ready_known || (status.ready_true != item.flag_value);
            status_next.ready_known = 1'b1;
            status_next.ready_true = item.flag_value;
            plan.res[0] = mk(rsgate_pkg::CMD_READY, rsgate_pkg::LVL_DEBUG,
                             rsgate_pkg::MSG_READY, 1'b0, rsgate_pkg::RSN_NONE,
                             item.flag_value, 8'd0, 11'd0);
            // A drop to not ready is followed by a snapshot of the updated status.
            if (changed && !item.flag_value) begin
               plan.res[1] = mk(rsgate_pkg::CMD_DIAG, rsgate_pkg::LVL_DEBUG,
                                rsgate_pkg::MSG_READY, 1'b0, rsgate_pkg::RSN_NONE, 1'b0,
                                8'd0, status_next);
               plan.res[2] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_READY);
               plan.cnt = 2'd3;
            end else begin
               plan.res[1] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_READY);
               plan.cnt = 2'd2;
            end
         end
         rsgate_pkg::FUNC_VELOCITY: begin
            status_next.velocity_known = 1'b1;
            status_next.vehicle_stopped = item.flag_value;
            plan.res[0] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_VELOCITY);
            plan.cnt = 2'd1;
         end
         rsgate_pkg::FUNC_CONTROL: begin
            status_next.control_known = 1'b1;
            status_next.control_auto = item.flag_value;
            plan.res[0] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_CONTROL);
            plan.cnt = 2'd1;
         end
         rsgate_pkg::FUNC_SWITCHER: begin
            changed = !status.switcher_known || (status.switcher_flags != new_flags);
            status_next.switcher_known = 1'b1;
            status_next.switcher_flags = new_flags;
            if (changed) begin
               plan.res[0] = mk(rsgate_pkg::CMD_DIAG, rsgate_pkg::LVL_DEBUG,
                                rsgate_pkg::MSG_SWITCHER, 1'b0, rsgate_pkg::RSN_NONE, 1'b0,
                                8'd0, status_next);
               plan.res[1] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_SWITCHER);
               plan.cnt = 2'd2;
            end else begin
               plan.res[0] = log_rsp(rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_SWITCHER);
               plan.cnt = 2'd1;
            end
         end
         rsgate_pkg::FUNC_UNIT: begin
            plan.res[0] = mk(rsgate_pkg::CMD_UNIT, rsgate_pkg::LVL_DEBUG,
                             rsgate_pkg::MSG_UNIT, 1'b0, rsgate_pkg::RSN_NONE, 1'b0,
                             item.unit_mask & rsgate_pkg::UNIT_KEEP, 11'd0);
            plan.cnt = 2'd1;
         end
         rsgate_pkg::FUNC_PEER: begin
            status_next.peer_timed_out = item.flag_value;
            plan.res[0] = mk(rsgate_pkg::CMD_PEER, rsgate_pkg::LVL_DEBUG,
                             rsgate_pkg::MSG_PEER, 1'b0, rsgate_pkg::RSN_NONE,
                             item.flag_value, 8'd0, 11'd0);
            plan.res[1] = log_rsp(item.flag_value ? rsgate_pkg::LVL_WARN :
                                  rsgate_pkg::LVL_INFO, rsgate_pkg::MSG_PEER);
            plan.cnt = 2'd2;
         end
         default: begin
            plan = '0;
         end
      endcase
   end

endmodule

### design/redundancy_switch_request_gate.sv
// Redundancy switch request gate: top level with request register, status and response buffer.
// Depends on rsgate_pkg, rsgate_decode and assert_macros.svh.
//
// Each request is held in an input register until the response buffer is free. It is
// then decoded in a single pass against the stored status, which is updated at the same
// edge. Its one to three responses are loaded into a response buffer and leave one per
// cycle while rsp_stall is low, the final one marked by rsp_last. A request therefore
// occupies the buffer until its last response is taken, so response stalls lengthen its
// stay. The single response port sets the sustained request rate. The input register
// takes a further request while the buffer still holds responses that are waiting to be
// taken.
`include "assert_macros.svh"

module redundancy_switch_request_gate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic        req_flag_value,
   input  logic        req_sw_stable,
   input  logic        req_sw_interrupted,
   input  logic        req_sw_fault,
   input  logic [7:0]  req_unit_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_cmd_kind,
   output logic [1:0]  rsp_log_level,
   output logic [4:0]  rsp_message_id,
   output logic        rsp_reset_accepted,
   output logic [1:0]  rsp_reject_reason,
   output logic        rsp_flag_out,
   output logic [7:0]  rsp_unit_out,
   output logic [10:0] rsp_status_word,
   output logic        rsp_last
);

   rsgate_pkg::req_type    item_ff;
   logic                   item_valid_ff;
   logic                   item_valid_in;
   rsgate_pkg::status_type status_ff;
   rsgate_pkg::status_type status_in;
   rsgate_pkg::plan_type   plan;
   rsgate_pkg::rsp_type [rsgate_pkg::RSP_DEPTH-1:0] buf_ff;
   logic [1:0]             buf_cnt_ff;
   logic [1:0]             buf_idx_ff;
   logic                   buf_valid_ff;
   rsgate_pkg::rsp_type    cur;
   logic                   take;
   logic                   buf_last;
   logic                   buf_free;
   logic                   load;
   logic                   req_accept;

   rsgate_decode u_decode (
      .item        (item_ff),
      .status      (status_ff),
      .plan        (plan),
      .status_next (status_in)
   );

   assign take = buf_valid_ff && !rsp_stall;
   assign buf_last = (buf_idx_ff == 2'(buf_cnt_ff - 2'd1));
   // The buffer can take the next request's responses once its last one leaves.
   assign buf_free = !buf_valid_ff || (take && buf_last);
   assign load = item_valid_ff && buf_free;
   assign req_stall = item_valid_ff && !buf_free;
   assign req_accept = req_valid && !req_stall;
   assign item_valid_in = req_accept || (item_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         buf_valid_ff <= 1'b0;
         buf_idx_ff <= 2'd0;
         buf_cnt_ff <= 2'd0;
         status_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (load) begin
            status_ff <= status_in;
            buf_valid_ff <= 1'b1;
            buf_idx_ff <= 2'd0;
            buf_cnt_ff <= plan.cnt;
         end else if (take) begin
            if (buf_last) begin
               buf_valid_ff <= 1'b0;
            end else begin
               buf_idx_ff <= 2'(buf_idx_ff + 2'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= '{func: rsgate_pkg::func_type'(req_func), flag_value: req_flag_value,
                      sw_stable: req_sw_stable, sw_interrupted: req_sw_interrupted,
                      sw_fault: req_sw_fault, unit_mask: req_unit_mask};
      end
      if (load) begin
         buf_ff <= plan.res;
      end
   end

   assign cur = buf_ff[buf_idx_ff];
   assign rsp_valid = buf_valid_ff;
   assign rsp_cmd_kind = cur.cmd_kind;
   assign rsp_log_level = cur.log_level;
   assign rsp_message_id = cur.message_id;
   assign rsp_reset_accepted = cur.reset_accepted;
   assign rsp_reject_reason = cur.reject_reason;
   assign rsp_flag_out = cur.flag_out;
   assign rsp_unit_out = cur.unit_out;
   assign rsp_status_word = cur.status_word;
   assign rsp_last = buf_last;

   `ASSERT_IMPLIES(a_idx_in_range, clock, reset, buf_valid_ff,
      (buf_cnt_ff != 2'd0) && (buf_idx_ff < buf_cnt_ff), "response index beyond count")
   `ASSERT_NEXT(a_buf_holds, clock, reset, buf_valid_ff && !take,
      buf_valid_ff && $stable(buf_idx_ff) && $stable(buf_cnt_ff), "waiting response moved")
   `ASSERT_NEXT(a_status_on_load, clock, reset, !load, $stable(status_ff),
      "status changed without a request being decoded")
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, load && buf_valid_ff,
      take && buf_last, "responses overwritten before delivery")

endmodule
